// ===== hw/rtl/cla_pkg.sv =====
package cla_pkg;

   // Line buffer size, 2 to 64 characters
   localparam int LINE_CAPACITY = 64;
   localparam int PTR_W = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1;

   typedef logic [PTR_W-1:0] ptr_type;
   typedef logic [7:0]       byte_type;

   // Highest buffer index; the write pointer wraps after it
   localparam ptr_type PTR_LAST = ptr_type'(LINE_CAPACITY - 1);

   // Control characters
   localparam byte_type BYTE_LF    = 8'd10;
   localparam byte_type BYTE_CR    = 8'd13;
   localparam byte_type BYTE_SPACE = 8'd32;

   typedef enum logic {
      ST_IDLE,
      ST_DRAIN
   } state_type;

endpackage

// ===== hw/rtl/cla_if.sv =====
// Received byte channel
interface cla_req_if;
   import cla_pkg::*;
   logic     valid;
   logic     ready;
   byte_type rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

// Line character channel
interface cla_rsp_if;
   import cla_pkg::*;
   logic     valid;
   logic     ready;
   byte_type line_char;
   logic     char_valid;
   logic     last_of_line;

   modport source (output valid, output line_char, output char_valid,
                   output last_of_line, input ready);
   modport sink   (input valid, input line_char, input char_valid,
                   input last_of_line, output ready);
endinterface

// ===== hw/rtl/command_line_assembler_core.sv =====
// Command line assembler.
// req_if carries one received byte per word. Carriage returns are dropped,
// spaces at the start of a line are dropped, and other bytes go into a
// line buffer (synchronous RAM, one write and one registered read port).
// The write pointer wraps to the start when the buffer is full.
// A line feed closes the line: the buffer is read out in order on rsp_if,
// one character per word, trailing spaces removed, the final word marked
// with last_of_line. An empty line gives one word with char_valid low.
// Throughput: one byte per cycle while a line is collected. After a line
// feed, req_if.ready stays low until the last word of the line has been
// issued to the read stage of the single RAM read port.
// The line feed sets ST_DRAIN; the first character then passes the RAM read
// stage and the output register. A stall on rsp_if holds the output register
// and the RAM read stage and pauses the readout; a stall after the last read
// holds only those registers; new bytes are already accepted.
// Reset clears pointers, state and valids; buffer contents are not cleared.
module command_line_assembler_core (
   input logic        clock,
   input logic        reset,
   cla_req_if.sink    req_if,
   cla_rsp_if.source  rsp_if
);
   import cla_pkg::*;

   state_type state_ff, state_in;
   ptr_type   wr_ptr_ff, wr_ptr_in;
   ptr_type   line_len_ff, line_len_in;
   ptr_type   drain_len_ff;
   ptr_type   rd_ptr_ff;
   logic      rd_pend_ff;
   logic      rd_last_ff;
   logic      rd_empty_ff;
   byte_type  rd_data_ff;
   logic      rsp_valid_ff;
   byte_type  rsp_char_ff;
   logic      rsp_cvalid_ff;
   logic      rsp_last_ff;

   byte_type  line_mem [LINE_CAPACITY];

   logic req_take, is_lf, is_cr, is_sp;
   logic store_en, line_done, wr_wrap;
   logic s0_move, issue, issue_last, drain_empty, mem_re;

   // Input decode
   assign req_take  = req_if.valid && req_if.ready;
   assign is_lf     = req_if.rx_byte == BYTE_LF;
   assign is_cr     = req_if.rx_byte == BYTE_CR;
   assign is_sp     = req_if.rx_byte == BYTE_SPACE;
   assign line_done = req_take && is_lf;
   assign store_en  = req_take && !is_lf && !is_cr && !(is_sp && wr_ptr_ff == '0);
   assign wr_wrap   = wr_ptr_ff == PTR_LAST;

   // Readout control: read stage moves on when the output register frees
   assign s0_move     = rd_pend_ff && (!rsp_valid_ff || rsp_if.ready);
   assign issue       = (state_ff == ST_DRAIN) && (!rd_pend_ff || s0_move);
   assign drain_empty = drain_len_ff == '0;
   assign issue_last  = drain_empty || (rd_ptr_ff == ptr_type'(drain_len_ff - 1'b1));
   assign mem_re      = issue && !drain_empty;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (line_done) state_in = ST_DRAIN;
         ST_DRAIN: if (issue && issue_last) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      unique case (state_ff)
         ST_IDLE:  req_if.ready = 1'b1;
         ST_DRAIN: req_if.ready = 1'b0;
         default:  req_if.ready = 1'b0;
      endcase
   end

   // Write pointer and trimmed length: length follows the last non-space
   always_comb begin
      wr_ptr_in   = wr_ptr_ff;
      line_len_in = line_len_ff;
      if (line_done) begin
         wr_ptr_in   = '0;
         line_len_in = '0;
      end else if (store_en) begin
         if (wr_wrap) begin
            wr_ptr_in   = '0;
            line_len_in = '0;
         end else begin
            wr_ptr_in = ptr_type'(wr_ptr_ff + 1'b1);
            if (!is_sp) line_len_in = ptr_type'(wr_ptr_ff + 1'b1);
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wr_ptr_ff    <= '0;
         line_len_ff  <= '0;
         drain_len_ff <= '0;
         rd_ptr_ff    <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         wr_ptr_ff   <= wr_ptr_in;
         line_len_ff <= line_len_in;
         if (line_done) begin
            drain_len_ff <= line_len_ff;
            rd_ptr_ff    <= '0;
         end else if (issue) begin
            rd_ptr_ff <= ptr_type'(rd_ptr_ff + 1'b1);
         end
         if (issue)        rd_pend_ff <= 1'b1;
         else if (s0_move) rd_pend_ff <= 1'b0;
         if (s0_move)             rsp_valid_ff <= 1'b1;
         else if (rsp_if.ready)   rsp_valid_ff <= 1'b0;
      end
   end

   // Line buffer RAM
   always_ff @(posedge clock) begin
      if (store_en) line_mem[wr_ptr_ff] <= req_if.rx_byte;
   end

   always_ff @(posedge clock) begin
      if (mem_re) rd_data_ff <= line_mem[rd_ptr_ff];
   end

   // Read stage tags and output word
   always_ff @(posedge clock) begin
      if (issue) begin
         rd_last_ff  <= issue_last;
         rd_empty_ff <= drain_empty;
      end
      if (s0_move) begin
         rsp_char_ff   <= rd_empty_ff ? '0 : rd_data_ff;
         rsp_cvalid_ff <= !rd_empty_ff;
         rsp_last_ff   <= rd_last_ff;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.line_char    = rsp_char_ff;
   assign rsp_if.char_valid   = rsp_cvalid_ff;
   assign rsp_if.last_of_line = rsp_last_ff;

   // An empty-line word is always the last of its line
   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_cvalid_ff |-> rsp_last_ff)
      else $error("empty line word without last mark");

   // Held read data stays put while the output is stalled
   a_rd_hold: assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff && !s0_move |=> $stable(rd_data_ff) && rd_pend_ff)
      else $error("read stage lost its data under stall");

   // A line feed starts a readout and resets the write pointer
   a_lf_drain: assert property (@(posedge clock) disable iff (reset)
      line_done |=> state_ff == ST_DRAIN && wr_ptr_ff == '0 && rd_ptr_ff == '0)
      else $error("line feed did not start readout");

endmodule
